/* rtl/tle_pkg.sv */
// shared constants, command type and codes for the terminal line editor
`timescale 1ns / 1ps

package tle_pkg;

    // default line capacity, one slot kept back as in the original editor
    localparam int DEF_LINE_CAPACITY = 32;

    // command queue between the classifier and the executor
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    // character codes
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_SP    = 8'h20;
    localparam logic [7:0] CH_LO_A  = 8'h61;
    localparam logic [7:0] CH_LO_Z  = 8'h7A;
    localparam logic [7:0] CH_UP_A  = 8'h41;
    localparam logic [7:0] CH_UP_Z  = 8'h5A;
    localparam logic [7:0] CH_DIG_0 = 8'h30;
    localparam logic [7:0] CH_DIG_9 = 8'h39;

    // result kinds
    localparam logic KIND_ECHO = 1'b0;
    localparam logic KIND_LINE = 1'b1;

    // command opcodes
    typedef logic [1:0] op_t;
    localparam op_t OP_ECHO  = 2'd0;
    localparam op_t OP_ERASE = 2'd1;
    localparam op_t OP_FLUSH = 2'd2;

    typedef struct packed {
        op_t        op;
        logic [7:0] data;
    } cmd_t;

endpackage

/* rtl/tle_front.sv */
// front end: classifies received bytes into editor commands
`timescale 1ns / 1ps

module tle_front
    import tle_pkg::*;
(
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    input  logic       q_full,
    output logic       push,
    output cmd_t       push_cmd
);

    logic is_print;
    logic is_eol;
    logic is_bs;

    // character classes
    always_comb begin
        is_print = (s_tdata inside {[CH_LO_A:CH_LO_Z], [CH_UP_A:CH_UP_Z],
                                    [CH_DIG_0:CH_DIG_9], CH_SP});
        is_eol   = (s_tdata inside {CH_LF, CH_CR});
        is_bs    = (s_tdata == CH_BS);
    end

    // build command, other bytes are taken and dropped
    always_comb begin
        push_cmd.data = s_tdata;
        push_cmd.op   = OP_ECHO;
        if (is_eol) begin
            push_cmd.op = OP_FLUSH;
        end else if (is_bs) begin
            push_cmd.op = OP_ERASE;
        end
    end

    assign s_tready = !q_full;
    assign push     = s_tvalid && !q_full && (is_print || is_eol || is_bs);

endmodule

/* rtl/tle_queue.sv */
// small command queue between front end and executor
`timescale 1ns / 1ps

module tle_queue
    import tle_pkg::*;
(
    input  logic aclk,
    input  logic aresetn,
    input  logic push,
    input  cmd_t push_cmd,
    output logic q_full,
    output logic q_valid,
    output cmd_t q_cmd,
    input  logic pop
);

    cmd_t              slot_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W:0]   count_reg;
    logic [QPTR_W:0]   count_next;
    logic              do_push;
    logic              do_pop;

    assign q_full  = (count_reg == (QPTR_W + 1)'(QUEUE_DEPTH));
    assign q_valid = (count_reg != '0);
    assign q_cmd   = slot_reg[rd_ptr_reg];
    assign do_push = push && !q_full;
    assign do_pop  = pop && q_valid;

    // occupancy
    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + (QPTR_W + 1)'(1);
        end else if (do_pop && !do_push) begin
            count_next = count_reg - (QPTR_W + 1)'(1);
        end
    end

    // pointers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    // storage
    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* rtl/tle_back.sv */
// executor: line store, echo sequencing and line flush
`timescale 1ns / 1ps

module tle_back
    import tle_pkg::*;
#(
    parameter int LINE_CAPACITY = DEF_LINE_CAPACITY,
    localparam int STORE_DEPTH  = LINE_CAPACITY - 1,
    localparam int CNT_W        = $clog2(LINE_CAPACITY),
    localparam int IDX_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    input  cmd_t             q_cmd,
    output logic             pop,
    output logic [CNT_W-1:0] fill_cnt,
    output logic             m_tvalid,
    input  logic             m_tready,
    output logic [7:0]       m_tdata,   // [7:0] out_byte
    output logic [1:0]       m_tuser,   // [0] out_kind, [1] line_empty
    output logic             m_tlast    // last
);

    localparam logic [1:0] ST_IDLE     = 2'd0;
    localparam logic [1:0] ST_ERASE_SP = 2'd1;
    localparam logic [1:0] ST_ERASE_BS = 2'd2;
    localparam logic [1:0] ST_FLUSH    = 2'd3;

    logic [1:0]       state_reg, state_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] rd_idx_reg, rd_idx_next;
    logic             out_valid_reg, out_valid_next;
    logic             out_kind_reg, out_kind_next;
    logic [7:0]       out_byte_reg, out_byte_next;
    logic             out_empty_reg, out_empty_next;
    logic             out_last_reg, out_last_next;

    logic [7:0]       store_mem [STORE_DEPTH];
    logic [7:0]       rd_data_reg;
    logic             rd_en;
    logic [IDX_W-1:0] rd_addr;
    logic             wr_en;
    logic [IDX_W-1:0] wr_addr;
    logic             slot_free;
    logic             line_last;

    assign slot_free = !out_valid_reg || m_tready;
    assign line_last = ((CNT_W'(rd_idx_reg) + CNT_W'(1)) == cnt_reg);
    assign wr_addr   = cnt_reg[IDX_W-1:0];

    // command sequencing
    always_comb begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        rd_idx_next    = rd_idx_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_kind_next  = out_kind_reg;
        out_byte_next  = out_byte_reg;
        out_empty_next = out_empty_reg;
        out_last_next  = out_last_reg;
        pop            = 1'b0;
        rd_en          = 1'b0;
        rd_addr        = '0;
        wr_en          = 1'b0;

        case (state_reg)
            ST_IDLE: begin
                if (slot_free && q_valid) begin
                    pop = 1'b1;
                    case (q_cmd.op)
                        OP_ECHO: begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_ECHO;
                            out_byte_next  = q_cmd.data;
                            out_empty_next = 1'b0;
                            out_last_next  = 1'b1;
                            if (cnt_reg < CNT_W'(STORE_DEPTH)) begin
                                wr_en    = 1'b1;
                                cnt_next = cnt_reg + CNT_W'(1);
                            end
                        end
                        OP_ERASE: begin
                            out_valid_next = 1'b1;
                            out_kind_next  = KIND_ECHO;
                            out_byte_next  = CH_BS;
                            out_empty_next = 1'b0;
                            out_last_next  = 1'b0;
                            state_next     = ST_ERASE_SP;
                            if (cnt_reg != '0) begin
                                cnt_next = cnt_reg - CNT_W'(1);
                            end
                        end
                        OP_FLUSH: begin
                            if (cnt_reg == '0) begin
                                out_valid_next = 1'b1;
                                out_kind_next  = KIND_LINE;
                                out_byte_next  = '0;
                                out_empty_next = 1'b1;
                                out_last_next  = 1'b1;
                            end else begin
                                rd_en       = 1'b1;
                                rd_addr     = '0;
                                rd_idx_next = '0;
                                state_next  = ST_FLUSH;
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            ST_ERASE_SP: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ECHO;
                    out_byte_next  = CH_SP;
                    out_empty_next = 1'b0;
                    out_last_next  = 1'b0;
                    state_next     = ST_ERASE_BS;
                end
            end
            ST_ERASE_BS: begin
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_ECHO;
                    out_byte_next  = CH_BS;
                    out_empty_next = 1'b0;
                    out_last_next  = 1'b1;
                    state_next     = ST_IDLE;
                end
            end
            ST_FLUSH: begin
                // read data for rd_idx is ready, fetch the next one as it goes out
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    out_kind_next  = KIND_LINE;
                    out_byte_next  = rd_data_reg;
                    out_empty_next = 1'b0;
                    out_last_next  = line_last;
                    if (line_last) begin
                        cnt_next   = '0;
                        state_next = ST_IDLE;
                    end else begin
                        rd_idx_next = rd_idx_reg + IDX_W'(1);
                        rd_en       = 1'b1;
                        rd_addr     = rd_idx_reg + IDX_W'(1);
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            rd_idx_reg    <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rd_idx_reg    <= rd_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // output payload
    always_ff @(posedge aclk) begin
        out_kind_reg  <= out_kind_next;
        out_byte_reg  <= out_byte_next;
        out_empty_reg <= out_empty_next;
        out_last_reg  <= out_last_next;
    end

    // line store with registered read
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= q_cmd.data;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[rd_addr];
        end
    end

    assign fill_cnt   = cnt_reg;
    assign m_tvalid   = out_valid_reg;
    assign m_tdata    = out_byte_reg;
    assign m_tuser[0] = out_kind_reg;
    assign m_tuser[1] = out_empty_reg;
    assign m_tlast    = out_last_reg;

endmodule

/* rtl/terminal_line_editor.sv */
// top level of the terminal line editor with echo
`timescale 1ns / 1ps
//
// Line editor for a serial terminal. Received bytes enter on the s_ stream,
// one byte per transaction in s_tdata. Results leave on the m_ stream:
// m_tdata carries the byte, m_tuser[0] tells an echo byte (0) from a line
// byte (1), m_tuser[1] flags an empty line, m_tlast marks the final result
// of one received byte.
// Letters, digits and space give one echo byte and are stored while room is
// left; backspace gives backspace, space, backspace and drops the last stored
// character; CR or LF sends the stored line and clears it. Other bytes are
// taken and give nothing.
// A front end classifies bytes into a four-entry command queue; the executor
// drains it. An echo result passes the queue slot and the output register,
// a line byte also the registered store read. A line goes out as one store
// read, then one byte per cycle from the registered store port while m_tready
// is high; a backspace gives three echo bytes.
// s_tready drops only while the command queue is full.
// A stall on m_tready holds the output register; the queue keeps taking bytes.
// Reset (aresetn low, synchronous) empties the queue and the line; the
// store contents are not cleared, since only written entries are ever read.
//
module terminal_line_editor
    import tle_pkg::*;
#(
    parameter int LINE_CAPACITY = DEF_LINE_CAPACITY
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] rx_byte
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] out_byte
    output logic [1:0] m_tuser,   // [0] out_kind, [1] line_empty
    output logic       m_tlast    // last
);

    localparam int STORE_DEPTH = LINE_CAPACITY - 1;
    localparam int CNT_W       = $clog2(LINE_CAPACITY);

    logic             q_full;
    logic             push;
    cmd_t             push_cmd;
    logic             q_valid;
    cmd_t             q_cmd;
    logic             pop;
    logic [CNT_W-1:0] fill_cnt;

    tle_front u_front (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    tle_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_cmd (push_cmd),
        .q_full   (q_full),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop)
    );

    tle_back #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_cmd    (q_cmd),
        .pop      (pop),
        .fill_cnt (fill_cnt),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

`ifndef SYNTH
    // an empty-line result is a line result and the only one for its byte
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[1]) |-> (m_tlast && m_tuser[0] == KIND_LINE))
        else $error("empty line flag on a non-final or echo result");

    // echo results never carry the empty flag
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser[0] == KIND_ECHO) |-> !m_tuser[1])
        else $error("echo result flagged as empty line");

    // fill count stays within the store
    assert property (@(posedge aclk) disable iff (!aresetn)
        fill_cnt <= CNT_W'(STORE_DEPTH))
        else $error("line fill count beyond store depth");
`endif

endmodule
